>>> hw/rtl/swr_pkg.sv
// Shared constants and codes for the spherical wall reflector.
`timescale 1ns / 1ps
`default_nettype none

package swr_pkg;

  // Configuration register indexes, in byte-address order (4 bytes each).
  typedef enum logic [2:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_ORIGIN_Z     = 3'd2,
    REG_START_RADIUS = 3'd3,
    REG_RADIUS_STEP  = 3'd4,
    REG_WALL_ENABLE  = 3'd5
  } reg_idx_t;

  localparam int ADDR_W = 5;

  // Item codes on the cmd field.
  localparam logic CMD_PARTICLE = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  // One result bit per stage in the square root and divider pipelines.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 33;

  // 0.1 in Q16.16.
  localparam logic [32:0] ROUGH_Q16 = 33'd6554;

endpackage

`default_nettype wire

>>> hw/rtl/swr_ifs.sv
// Valid/ready stream interfaces for particle words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface swr_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic               in_group;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source (output valid, cmd, in_group, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  input ready);
  modport sink (input valid, cmd, in_group, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                output ready);
endinterface

interface swr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;
  logic               reflected;

  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, reflected, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                new_vel_z, reflected, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/swr_isqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module swr_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] sq,
  output logic [31:0] root
);
  import swr_pkg::*;

  logic [63:0] rem_q [SQRT_STEPS];
  logic [63:0] res_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] rem_in;
    logic [63:0] res_in;
    logic [63:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = sq;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + BIT;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_q[SQRT_STEPS-1][31:0];

endmodule

`default_nettype wire

>>> hw/rtl/swr_udiv.sv
// Pipelined restoring divider: 64-bit dividend, 33-bit divisor, 33-bit quotient.
`timescale 1ns / 1ps
`default_nettype none

module swr_udiv (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic [32:0] quo
);
  import swr_pkg::*;

  // Each stage holds {partial remainder, remaining dividend bits / quotient bits}.
  // The caller guarantees the quotient fits in 33 bits, so the top 31 dividend
  // bits start out below the divisor.
  logic [65:0] acc_q [DIV_STEPS];
  logic [32:0] den_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [65:0] acc_in;
    logic [32:0] den_in;
    logic [33:0] rem_sh;
    logic [33:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign acc_in = {2'b00, num};
      assign den_in = den;
    end else begin : g_next
      assign acc_in = acc_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign rem_sh = acc_in[65:32];
    assign diff   = rem_sh - {1'b0, den_in};
    assign ge     = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        acc_q[k] <= {(ge ? diff[32:0] : rem_sh[32:0]), acc_in[31:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo = acc_q[DIV_STEPS-1][32:0];

endmodule

`default_nettype wire

>>> hw/rtl/spherical_wall_particle_reflect_unit.sv
// Top level of the spherical wall reflector: config registers, pipeline, output skid.
//
// Usage. Words enter on the items channel (valid/ready). A word with cmd set
// is a timestep tick: while the wall is enabled it adds radius_step to the
// current radius (saturating) and produces no result. Any other word is a
// particle and produces exactly one result word on the results channel, in
// the order the particles were accepted. A particle of the affected group
// that lies outside the sphere has its position pulled back inside and its
// velocity mirrored about the surface normal; reflected is then set.
// Timing. The datapath is a 74-stage pipeline: a 32-stage square root, a
// 33-stage divider and short multiply stages around them. One word can be
// accepted in every cycle while the skid register is empty (items.ready
// high); the pipeline is single-issue.
// Stalls. A result register plus one skid register follow the pipeline. When
// the receiver holds ready low, the next finished result parks in the skid
// register and the whole pipeline, including items.ready, freezes until the
// skid drains. Nothing is dropped or duplicated.
// Reset. rst (synchronous) clears the configuration registers, the current
// radius and every valid bit. Configuration goes through the APB port; write
// only when idle.
`timescale 1ns / 1ps
`default_nettype none

module spherical_wall_particle_reflect_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [swr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  swr_in_if.sink                    items,
  swr_out_if.source                 results
);
  import swr_pkg::*;

  // Delay line length from the square root input to the divider output.
  localparam int LINE_LEN = SQRT_STEPS + 1 + DIV_STEPS;
  localparam int DIV_TAP  = SQRT_STEPS - 1;

  typedef struct packed {
    logic             refl;
    logic             rneg;
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
    logic [2:0][31:0] d;
    logic [2:0][63:0] numq;
  } line_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic             refl;
  } res_t;

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [39:0] sx40(input logic [31:0] x);
    return {{8{x[31]}}, x};
  endfunction

  function automatic logic [31:0] sat32(input logic signed [39:0] x);
    if (x > 40'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (x < -40'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

  // Arithmetic shift right by 30 that truncates toward zero.
  function automatic logic signed [69:0] shr30(input logic signed [69:0] x);
    logic [69:0] m;
    m = x[69] ? (70'd0 - x) : x;
    m = m >> 30;
    return x[69] ? $signed(70'd0 - m) : $signed(m);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0][31:0] origin;
  logic [30:0]      start_radius;
  logic [31:0]      radius_step;
  logic             wall_enable;
  logic [31:0]      cur_radius;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    case (cfg_idx)
      REG_ORIGIN_X:     prdata = origin[0];
      REG_ORIGIN_Y:     prdata = origin[1];
      REG_ORIGIN_Z:     prdata = origin[2];
      REG_START_RADIUS: prdata = {1'b0, start_radius};
      REG_RADIUS_STEP:  prdata = radius_step;
      REG_WALL_ENABLE:  prdata = {31'd0, wall_enable};
      default:          prdata = '0;
    endcase
  end

  // Pipeline handshake: the pipeline moves unless the skid register is full.
  logic en;
  logic accept;
  logic take_part;
  logic take_tick;
  logic skid_valid;

  assign en          = ~skid_valid;
  assign items.ready = en;
  assign accept      = items.valid & en;
  assign take_part   = accept & (items.cmd == CMD_PARTICLE);
  assign take_tick   = accept & (items.cmd == CMD_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin       <= '0;
      start_radius <= '0;
      radius_step  <= '0;
      wall_enable  <= 1'b0;
      cur_radius   <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_ORIGIN_X:     origin[0] <= pwdata;
          REG_ORIGIN_Y:     origin[1] <= pwdata;
          REG_ORIGIN_Z:     origin[2] <= pwdata;
          REG_START_RADIUS: begin
            start_radius <= pwdata[30:0];
            cur_radius   <= {1'b0, pwdata[30:0]};
          end
          REG_RADIUS_STEP:  radius_step <= pwdata;
          REG_WALL_ENABLE:  wall_enable <= pwdata[0];
          default:          ;
        endcase
      end else if (take_tick && wall_enable) begin
        cur_radius <= sat32(sx40(cur_radius) + sx40(radius_step));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the word, form the saturated offset from the origin.
  // The radius is sampled here, so a particle sees every earlier tick.
  // ---------------------------------------------------------------------------
  logic [2:0][31:0] in_p;
  logic [2:0][31:0] in_v;

  assign in_p = {items.pos_z, items.pos_y, items.pos_x};
  assign in_v = {items.vel_z, items.vel_y, items.vel_x};

  logic             vld1;
  logic             act1;
  logic             rneg1;
  logic [31:0]      rmag1;
  logic [2:0][31:0] p1;
  logic [2:0][31:0] v1;
  logic [2:0][31:0] d1;
  logic [2:0][31:0] dmag1;

  always_ff @(posedge clk) begin
    if (en) begin
      act1  <= items.in_group & wall_enable;
      rneg1 <= cur_radius[31];
      rmag1 <= mag32(cur_radius);
      p1    <= in_p;
      v1    <= in_v;
      for (int i = 0; i < 3; i++) begin
        d1[i] <= sat32(sx40(in_p[i]) - sx40(origin[i]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag1[i] = mag32(d1[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares of the offset and radius, and the scale numerators R*|d|.
  // ---------------------------------------------------------------------------
  logic             vld2;
  logic             act2;
  logic             rneg2;
  logic [63:0]      r2_2;
  logic [2:0][63:0] sq2;
  logic [2:0][63:0] numq2;
  logic [2:0][31:0] p2;
  logic [2:0][31:0] v2;
  logic [2:0][31:0] d2;

  always_ff @(posedge clk) begin
    if (en) begin
      act2  <= act1;
      rneg2 <= rneg1;
      r2_2  <= 64'(rmag1) * 64'(rmag1);
      p2    <= p1;
      v2    <= v1;
      d2    <= d1;
      for (int i = 0; i < 3; i++) begin
        sq2[i]   <= 64'(dmag1[i]) * 64'(dmag1[i]);
        numq2[i] <= 64'(rmag1) * 64'(dmag1[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squared distance. The outside test is made as the word enters the
  // delay line that runs beside the square root and divider pipelines.
  // ---------------------------------------------------------------------------
  logic             vld3;
  logic             act3;
  logic             rneg3;
  logic [63:0]      r2_3;
  logic [63:0]      dist3;
  logic [2:0][63:0] numq3;
  logic [2:0][31:0] p3;
  logic [2:0][31:0] v3;
  logic [2:0][31:0] d3;

  always_ff @(posedge clk) begin
    if (en) begin
      act3  <= act2;
      rneg3 <= rneg2;
      r2_3  <= r2_2;
      dist3 <= sq2[0] + sq2[1] + sq2[2];
      numq3 <= numq2;
      p3    <= p2;
      v3    <= v2;
      d3    <= d2;
    end
  end

  line_t                line_in;
  line_t                line_q [LINE_LEN];
  logic [LINE_LEN-1:0]  line_vld;

  always_comb begin
    line_in.refl = act3 & (dist3 > r2_3);
    line_in.rneg = rneg3;
    line_in.p    = p3;
    line_in.v    = v3;
    line_in.d    = d3;
    line_in.numq = numq3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_q[0] <= line_in;
      for (int k = 1; k < LINE_LEN; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Square root of the squared distance: r = floor(sqrt(|d|^2)).
  // ---------------------------------------------------------------------------
  logic [31:0] root;

  swr_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .sq   (dist3),
    .root (root)
  );

  // ---------------------------------------------------------------------------
  // Divider operands. The position scale divides 2R|d| by r + 0.1, and the
  // normal divides |d| * 2^30 by r (forced to at least one).
  // ---------------------------------------------------------------------------
  logic [32:0]      den_q36;
  logic [32:0]      den_n36;
  logic [2:0][63:0] num_q36;
  logic [2:0][63:0] num_n36;

  always_ff @(posedge clk) begin
    if (en) begin
      den_q36 <= {1'b0, root} + ROUGH_Q16;
      den_n36 <= (root == 32'd0) ? 33'd1 : {1'b0, root};
      for (int i = 0; i < 3; i++) begin
        num_q36[i] <= {line_q[DIV_TAP].numq[i][62:0], 1'b0};
        num_n36[i] <= {2'b00, mag32(line_q[DIV_TAP].d[i]), 30'd0};
      end
    end
  end

  logic [2:0][32:0] qmag;
  logic [2:0][32:0] nmag;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    swr_udiv u_div_q (
      .clk (clk),
      .en  (en),
      .num (num_q36[g]),
      .den (den_q36),
      .quo (qmag[g])
    );

    swr_udiv u_div_n (
      .clk (clk),
      .en  (en),
      .num (num_n36[g]),
      .den (den_n36),
      .quo (nmag[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 70: signed scale term and new position; signed normal in Q2.30.
  // ---------------------------------------------------------------------------
  line_t            lend;
  logic             vld70;
  logic             refl70;
  logic [2:0][31:0] p70;
  logic [2:0][31:0] v70;
  logic [2:0][31:0] np70;
  logic [2:0][31:0] n70;
  logic [2:0][33:0] qs;

  assign lend = line_q[LINE_LEN-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = (lend.rneg ^ lend.d[i][31]) ? (34'd0 - {1'b0, qmag[i]}) : {1'b0, qmag[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      refl70 <= lend.refl;
      p70    <= lend.p;
      v70    <= lend.v;
      for (int i = 0; i < 3; i++) begin
        np70[i] <= sat32(sx40(origin[i]) + {{6{qs[i][33]}}, qs[i]} - sx40(lend.d[i]));
        n70[i]  <= lend.d[i][31] ? (32'd0 - nmag[i][31:0]) : nmag[i][31:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 71 to 74: vn = (n . v) / 2^30, then v - 2 n vn / 2^30.
  // ---------------------------------------------------------------------------
  logic             vld71;
  logic             refl71;
  logic [2:0][31:0] p71;
  logic [2:0][31:0] v71;
  logic [2:0][31:0] np71;
  logic [2:0][31:0] n71;
  logic [2:0][63:0] prod71;

  always_ff @(posedge clk) begin
    if (en) begin
      refl71 <= refl70;
      p71    <= p70;
      v71    <= v70;
      np71   <= np70;
      n71    <= n70;
      for (int i = 0; i < 3; i++) begin
        prod71[i] <= $signed(n70[i]) * $signed(v70[i]);
      end
    end
  end

  logic signed [69:0] dot71;
  logic signed [69:0] vn_full;

  assign dot71   = $signed({{6{prod71[0][63]}}, prod71[0]})
                 + $signed({{6{prod71[1][63]}}, prod71[1]})
                 + $signed({{6{prod71[2][63]}}, prod71[2]});
  assign vn_full = shr30(dot71);

  logic             vld72;
  logic             refl72;
  logic [2:0][31:0] p72;
  logic [2:0][31:0] v72;
  logic [2:0][31:0] np72;
  logic [2:0][31:0] n72;
  logic [35:0]      vn72;

  always_ff @(posedge clk) begin
    if (en) begin
      refl72 <= refl71;
      p72    <= p71;
      v72    <= v71;
      np72   <= np71;
      n72    <= n71;
      vn72   <= vn_full[35:0];
    end
  end

  logic             vld73;
  logic             refl73;
  logic [2:0][31:0] p73;
  logic [2:0][31:0] v73;
  logic [2:0][31:0] np73;
  logic [2:0][67:0] m73;

  always_ff @(posedge clk) begin
    if (en) begin
      refl73 <= refl72;
      p73    <= p72;
      v73    <= v72;
      np73   <= np72;
      for (int i = 0; i < 3; i++) begin
        m73[i] <= $signed(n72[i]) * $signed(vn72);
      end
    end
  end

  logic [2:0][69:0] corr73;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      corr73[i] = shr30($signed({m73[i][67], m73[i], 1'b0}));
    end
  end

  logic             vld74;
  logic             refl74;
  logic [2:0][31:0] p74;
  logic [2:0][31:0] v74;
  logic [2:0][31:0] np74;
  logic [2:0][31:0] nv74;

  always_ff @(posedge clk) begin
    if (en) begin
      refl74 <= refl73;
      p74    <= p73;
      v74    <= v73;
      np74   <= np73;
      for (int i = 0; i < 3; i++) begin
        nv74[i] <= sat32(sx40(v73[i]) - $signed(corr73[i][39:0]));
      end
    end
  end

  // Valid bits travel beside the data and are the only pipeline state reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1     <= 1'b0;
      vld2     <= 1'b0;
      vld3     <= 1'b0;
      line_vld <= '0;
      vld70    <= 1'b0;
      vld71    <= 1'b0;
      vld72    <= 1'b0;
      vld73    <= 1'b0;
      vld74    <= 1'b0;
    end else if (en) begin
      vld1     <= take_part;
      vld2     <= vld1;
      vld3     <= vld2;
      line_vld <= {line_vld[LINE_LEN-2:0], vld3};
      vld70    <= line_vld[LINE_LEN-1];
      vld71    <= vld70;
      vld72    <= vld71;
      vld73    <= vld72;
      vld74    <= vld73;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid register.
  // ---------------------------------------------------------------------------
  res_t pipe_res;
  res_t res_q;
  res_t skid_q;
  logic res_valid;
  logic pop;
  logic push;

  assign pipe_res.pos  = refl74 ? np74 : p74;
  assign pipe_res.vel  = refl74 ? nv74 : v74;
  assign pipe_res.refl = refl74;

  assign pop  = res_valid & results.ready;
  assign push = en & vld74;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        res_q      <= skid_q;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!res_valid || pop) begin
        res_q     <= pipe_res;
        res_valid <= 1'b1;
      end else begin
        skid_q     <= pipe_res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  assign results.valid     = res_valid;
  assign results.new_pos_x = res_q.pos[0];
  assign results.new_pos_y = res_q.pos[1];
  assign results.new_pos_z = res_q.pos[2];
  assign results.new_vel_x = res_q.vel[0];
  assign results.new_vel_y = res_q.vel[1];
  assign results.new_vel_z = res_q.vel[2];
  assign results.reflected = res_q.refl;

endmodule

`default_nettype wire

>>> hw/rtl/swr_checker.sv
// Port-level checks for the spherical wall reflector, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module swr_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       in_ready,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [31:0]                out_pos_x,
  input  logic [31:0]                out_vel_x,
  input  logic                       out_refl
);
  import swr_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_ORIGIN_X = ADDR_W'(REG_ORIGIN_X) << 2;

  // No result may be offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result holds its word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_vel_x)
                                && $stable(out_refl))
    else $error("stalled result changed");

  // The input side only backs up after the receiver stalled a waiting result.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without an output stall");

  // A write to the origin X register reads back the written data while it is addressed.
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr == ADDR_ORIGIN_X
    |=> paddr != ADDR_ORIGIN_X || prdata == $past(pwdata))
    else $error("origin register readback mismatch");

endmodule

bind spherical_wall_particle_reflect_unit swr_checker u_swr_checker (
  .clk       (clk),
  .rst       (rst),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_pos_x (results.new_pos_x),
  .out_vel_x (results.new_vel_x),
  .out_refl  (results.reflected)
);

`default_nettype wire
